@@ rtl/assert_macros.svh @@
// ------------------------------------------------------------------------
// assertion macros
// property forms for the checker module
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

@@ rtl/tpft_pkg.sv @@
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// tpft_pkg
// types, constants and helpers of the taxel force and torque unit
// ------------------------------------------------------------------------
package tpft_pkg;

    localparam int TAXEL_COUNT = 256;
    localparam int MAX_ORDER   = 3;
    localparam int SLOT_W      = 2;
    localparam int TAXEL_AW    = (TAXEL_COUNT > 1) ? $clog2(TAXEL_COUNT) : 1;
    localparam int COEF_AW     = TAXEL_AW + SLOT_W;
    localparam int COEF_DEPTH  = TAXEL_COUNT * (2 ** SLOT_W);
    localparam int COEF_W      = 32;
    localparam int VEC_W       = 16;
    localparam int LEVER_W     = VEC_W + 1;
    localparam int SUM_W       = 48;
    localparam int TQ_W        = SUM_W + 7;
    localparam int ORDER_W     = 2;
    localparam int AREA_W      = 24;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 24;
    localparam int INVERT_BASE = 255;
    localparam int X_W         = 9;

    typedef enum logic [1:0] {
        KIND_COEF,
        KIND_NORMAL,
        KIND_ORIGIN,
        KIND_SAMPLE
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POLY_ORDER,
        REG_AREA_SCALE
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD0,
        ST_POLY,
        ST_AREA_LO,
        ST_AREA_HI,
        ST_FORCE,
        ST_TORQUE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        kind_t                    kind;
        logic [7:0]               taxel_id;
        logic [1:0]               coef_index;
        logic signed [COEF_W-1:0] coef_value;
        logic signed [VEC_W-1:0]  vec_x;
        logic signed [VEC_W-1:0]  vec_y;
        logic signed [VEC_W-1:0]  vec_z;
        logic [7:0]               raw_reading;
        logic                     last_taxel;
    } sample_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] force_x;
        logic signed [SUM_W-1:0] force_y;
        logic signed [SUM_W-1:0] force_z;
        logic signed [SUM_W-1:0] torque_x;
        logic signed [SUM_W-1:0] torque_y;
        logic signed [SUM_W-1:0] torque_z;
    } result_t;

    function automatic logic signed [SUM_W-1:0] sat48(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sh0000_7FFF_FFFF_FFFF;
        lo = -hi - 64'sd1;
        if (v > hi)
            return hi[SUM_W-1:0];
        else if (v < lo)
            return lo[SUM_W-1:0];
        else
            return v[SUM_W-1:0];
    endfunction

    // cross product walk: lever component per step
    function automatic logic [1:0] lever_sel(input logic [2:0] k);
        case (k)
            3'd0:    return 2'd1;
            3'd1:    return 2'd2;
            3'd2:    return 2'd2;
            3'd3:    return 2'd0;
            3'd4:    return 2'd0;
            3'd5:    return 2'd1;
            default: return 2'd0;
        endcase
    endfunction

    // cross product walk: force component per step
    function automatic logic [1:0] force_sel(input logic [2:0] k);
        case (k)
            3'd0:    return 2'd2;
            3'd1:    return 2'd1;
            3'd2:    return 2'd0;
            3'd3:    return 2'd2;
            3'd4:    return 2'd1;
            3'd5:    return 2'd0;
            default: return 2'd0;
        endcase
    endfunction

endpackage

@@ rtl/tpft_in_if.sv @@
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// tpft_in_if
// input item channel: valid, ready and one load or sample item
// ------------------------------------------------------------------------
interface tpft_in_if;
    logic              valid;
    logic              ready;
    tpft_pkg::sample_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/tpft_out_if.sv @@
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// tpft_out_if
// result channel: valid, ready and one force and torque item
// ------------------------------------------------------------------------
interface tpft_out_if;
    logic              valid;
    logic              ready;
    tpft_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/tpft_ram.sv @@
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// tpft_ram
// generic single write, single read ram with registered read data
// ------------------------------------------------------------------------
module tpft_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/taxel_polynomial_force_torque_unit.sv @@
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// taxel_polynomial_force_torque_unit
// per-taxel polynomial calibration, force along the taxel normal and
// torque about the centre of pressure, summed over a contact
//
//   channel   dir   handshake      payload
//   sample    in    valid/ready    load or sample item
//   result    out   valid/ready    force and torque sums
//   cfg       in    cfg_we         cfg_index, cfg_data
//
// a load item is a single ram write, and the block stays ready
// a sample steps through load, one coefficient ram read per horner
// step, a low and a high area multiply, three force and six torque
// multiplier steps and finish; a sample of an unknown taxel goes
// straight to finish; a last sample waits in finish while the result
// register is full and not taken; rams need no clearing after reset
// ------------------------------------------------------------------------
module taxel_polynomial_force_torque_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [tpft_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tpft_pkg::CFG_DATA_W-1:0]     cfg_data,
    tpft_in_if.sink                             sample,
    tpft_out_if.source                          result
);
    import tpft_pkg::*;

    state_t                   state_reg;
    state_t                   state_next;
    logic [2:0]               step_reg;
    logic [2:0]               step_next;
    logic [ORDER_W-1:0]       order_reg;
    logic [AREA_W-1:0]        area_reg;
    logic [ORDER_W-1:0]       order_eff;

    logic [TAXEL_AW-1:0]      id_reg;
    logic                     hit_reg;
    logic                     last_reg;
    logic signed [X_W-1:0]    x_reg;
    logic signed [VEC_W-1:0]  cop_reg [3];
    logic signed [SUM_W-1:0]  acc_reg;
    logic [SUM_W-1:0]         prod_lo_reg;
    logic signed [SUM_W-1:0]  mag_reg;
    logic signed [SUM_W-1:0]  f_reg [3];
    logic signed [TQ_W-1:0]   tq_reg [3];
    logic signed [SUM_W-1:0]  fsum_reg [3];
    logic signed [SUM_W-1:0]  tsum_reg [3];
    logic signed [SUM_W-1:0]  fsum_new [3];
    logic signed [SUM_W-1:0]  tsum_new [3];
    logic                     out_valid_reg;
    result_t                  out_data_reg;

    logic                     accept;
    logic                     in_hit;
    logic                     is_sample;
    logic                     finish_go;
    logic [TAXEL_AW-1:0]      in_id;

    logic                     coef_we;
    logic [COEF_AW-1:0]       coef_waddr;
    logic                     coef_re;
    logic [COEF_AW-1:0]       coef_raddr;
    logic [COEF_W-1:0]        coef_rdata;
    logic                     normal_we;
    logic                     origin_we;
    logic                     vec_re;
    logic [3*VEC_W-1:0]       vec_wdata;
    logic [3*VEC_W-1:0]       normal_rdata;
    logic [3*VEC_W-1:0]       origin_rdata;

    logic signed [56:0]       horner_prod;
    logic signed [63:0]       horner_sum;
    logic [SUM_W-1:0]         area_lo_prod;
    logic signed [48:0]       area_hi_prod;
    logic signed [48:0]       mag_wide;
    logic signed [VEC_W-1:0]  normal_sel;
    logic signed [63:0]       force_prod;
    logic [1:0]               lsel;
    logic [1:0]               fsel;
    logic signed [VEC_W-1:0]  origin_sel;
    logic signed [LEVER_W-1:0] lever;
    logic signed [64:0]       torque_prod;
    logic signed [64:0]       torque_shift;

    assign order_eff = (order_reg > MAX_ORDER) ? ORDER_W'(MAX_ORDER) : order_reg;
    assign accept    = sample.valid && sample.ready;
    assign in_id     = TAXEL_AW'(sample.data.taxel_id);
    assign in_hit    = ({24'd0, sample.data.taxel_id} < TAXEL_COUNT);
    assign is_sample = (sample.data.kind == KIND_SAMPLE);
    assign finish_go = !last_reg || !out_valid_reg || result.ready;

    // table writes straight from load items
    assign coef_we    = accept && (sample.data.kind == KIND_COEF) && in_hit
                        && ({30'd0, sample.data.coef_index} <= MAX_ORDER);
    assign coef_waddr = {in_id, sample.data.coef_index};
    assign normal_we  = accept && (sample.data.kind == KIND_NORMAL) && in_hit;
    assign origin_we  = accept && (sample.data.kind == KIND_ORIGIN) && in_hit;
    assign vec_wdata  = {sample.data.vec_z, sample.data.vec_y, sample.data.vec_x};

    tpft_ram #(.WIDTH(COEF_W), .DEPTH(COEF_DEPTH)) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (sample.data.coef_value),
        .re    (coef_re),
        .raddr (coef_raddr),
        .rdata (coef_rdata)
    );

    tpft_ram #(.WIDTH(3*VEC_W), .DEPTH(TAXEL_COUNT)) u_normal_ram (
        .clk   (clk),
        .we    (normal_we),
        .waddr (in_id),
        .wdata (vec_wdata),
        .re    (vec_re),
        .raddr (in_id),
        .rdata (normal_rdata)
    );

    tpft_ram #(.WIDTH(3*VEC_W), .DEPTH(TAXEL_COUNT)) u_origin_ram (
        .clk   (clk),
        .we    (origin_we),
        .waddr (in_id),
        .wdata (vec_wdata),
        .re    (vec_re),
        .raddr (in_id),
        .rdata (origin_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_sample)
                begin
                    state_next = in_hit ? ST_LOAD0 : ST_FINISH;
                end
            end
            ST_LOAD0:
            begin
                step_next  = 3'd1;
                state_next = (order_eff == '0) ? ST_AREA_LO : ST_POLY;
            end
            ST_POLY:
            begin
                step_next = step_reg + 3'd1;
                if (step_reg[ORDER_W-1:0] == order_eff)
                begin
                    state_next = ST_AREA_LO;
                end
            end
            ST_AREA_LO:
            begin
                state_next = ST_AREA_HI;
            end
            ST_AREA_HI:
            begin
                step_next  = 3'd0;
                state_next = ST_FORCE;
            end
            ST_FORCE:
            begin
                if (step_reg == 3'd2)
                begin
                    step_next  = 3'd0;
                    state_next = ST_TORQUE;
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end
            ST_TORQUE:
            begin
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd5)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (finish_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        sample.ready = 1'b0;
        coef_re      = 1'b0;
        coef_raddr   = {id_reg, SLOT_W'(0)};
        vec_re       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                sample.ready = 1'b1;
                coef_re      = sample.valid && is_sample;
                coef_raddr   = {in_id, SLOT_W'(0)};
                vec_re       = sample.valid && is_sample;
            end
            ST_LOAD0:
            begin
                coef_re    = (order_eff != '0);
                coef_raddr = {id_reg, SLOT_W'(1)};
            end
            ST_POLY:
            begin
                coef_re    = (step_reg[ORDER_W-1:0] != order_eff);
                coef_raddr = {id_reg, step_reg[SLOT_W-1:0] + SLOT_W'(1)};
            end
            default:
            begin
                sample.ready = 1'b0;
            end
        endcase
    end

    // arithmetic
    assign horner_prod  = acc_reg * x_reg;
    assign horner_sum   = 64'(horner_prod) + 64'($signed(coef_rdata));
    assign area_lo_prod = acc_reg[23:0] * area_reg;
    assign area_hi_prod = $signed(acc_reg[47:24]) * $signed({1'b0, area_reg});
    assign mag_wide     = area_hi_prod + $signed({25'd0, prod_lo_reg[47:24]});
    assign normal_sel   = $signed(normal_rdata[step_reg[1:0]*VEC_W +: VEC_W]);
    assign force_prod   = mag_reg * normal_sel;
    assign lsel         = lever_sel(step_reg);
    assign fsel         = force_sel(step_reg);
    assign origin_sel   = $signed(origin_rdata[lsel*VEC_W +: VEC_W]);
    assign lever        = origin_sel - cop_reg[lsel];
    assign torque_prod  = lever * f_reg[fsel];
    assign torque_shift = torque_prod >>> 12;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            fsum_new[i] = sat48(64'(fsum_reg[i]) + (hit_reg ? 64'(f_reg[i]) : 64'sd0));
            tsum_new[i] = sat48(64'(tsum_reg[i]) + (hit_reg ? 64'(tq_reg[i]) : 64'sd0));
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_sample)
                begin
                    id_reg     <= in_id;
                    hit_reg    <= in_hit;
                    last_reg   <= sample.data.last_taxel;
                    x_reg      <= X_W'(INVERT_BASE) - X_W'(sample.data.raw_reading);
                    cop_reg[0] <= sample.data.vec_x;
                    cop_reg[1] <= sample.data.vec_y;
                    cop_reg[2] <= sample.data.vec_z;
                end
            end
            ST_LOAD0:
            begin
                acc_reg <= SUM_W'($signed(coef_rdata));
            end
            ST_POLY:
            begin
                acc_reg <= sat48(horner_sum);
            end
            ST_AREA_LO:
            begin
                prod_lo_reg <= area_lo_prod;
            end
            ST_AREA_HI:
            begin
                mag_reg <= mag_wide[SUM_W-1:0];
            end
            ST_FORCE:
            begin
                f_reg[step_reg[1:0]] <= sat48(force_prod >>> 14);
            end
            ST_TORQUE:
            begin
                if (step_reg[0])
                    tq_reg[step_reg[2:1]] <= tq_reg[step_reg[2:1]]
                                             - TQ_W'(torque_shift);
                else
                    tq_reg[step_reg[2:1]] <= TQ_W'(torque_shift);
            end
            default:
            begin
            end
        endcase
        if (state_reg == ST_FINISH && finish_go && last_reg)
        begin
            out_data_reg.force_x  <= fsum_new[0];
            out_data_reg.force_y  <= fsum_new[1];
            out_data_reg.force_z  <= fsum_new[2];
            out_data_reg.torque_x <= tsum_new[0];
            out_data_reg.torque_y <= tsum_new[1];
            out_data_reg.torque_z <= tsum_new[2];
        end
    end

    // control and sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                fsum_reg[i] <= '0;
                tsum_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (state_reg == ST_FINISH && finish_go && last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_FINISH && finish_go)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    fsum_reg[i] <= last_reg ? '0 : fsum_new[i];
                    tsum_reg[i] <= last_reg ? '0 : tsum_new[i];
                end
            end
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= ORDER_W'(1);
            area_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_POLY_ORDER: order_reg <= cfg_data[ORDER_W-1:0];
                REG_AREA_SCALE: area_reg  <= cfg_data[AREA_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

endmodule

@@ rtl/tpft_checker.sv @@
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// tpft_checker
// port-level checks on the taxel force and torque unit
// ------------------------------------------------------------------------
`include "assert_macros.svh"

module tpft_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input tpft_pkg::kind_t in_kind,
    input logic            out_valid,
    input logic            out_ready
);
    import tpft_pkg::*;

    // result item holds until taken
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

    // after a load item the block is ready again in the next cycle
    `ASSERT_NEXT(a_load_one, clk, rst_n,
        in_valid && in_ready && in_kind != KIND_SAMPLE, in_ready)

    // a sample occupies the block
    `ASSERT_NEXT(a_sample_busy, clk, rst_n,
        in_valid && in_ready && in_kind == KIND_SAMPLE, !in_ready)

    // a result appears as the block returns to idle
    `ASSERT_NOW(a_emit_idle, clk, rst_n, $rose(out_valid), in_ready && !$past(in_ready))

endmodule

bind taxel_polynomial_force_torque_unit tpft_checker u_tpft_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .in_kind   (sample.data.kind),
    .out_valid (result.valid),
    .out_ready (result.ready)
);

@@ tb/taxel_polynomial_force_torque_unit_tb.sv @@
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// taxel_polynomial_force_torque_unit_tb
// self-checking bench: table of directed items, then random contacts over
// a changing configuration; every result is compared with a local model
// of the polynomial, force and torque sums
// ------------------------------------------------------------------------
module taxel_polynomial_force_torque_unit_tb;
    import tpft_pkg::*;

    localparam longint S48_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint S48_LO = -S48_HI - 64'sd1;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int N_RANDOM = 1250;

    typedef struct {
        sample_t item;
        bit      has_value;
        result_t value;
    } row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tpft_in_if sample_ch ();
    tpft_out_if result_ch ();

    taxel_polynomial_force_torque_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .sample(sample_ch.sink),
        .result(result_ch.source)
    );

    // local copy of block state
    logic signed [31:0] coef_mem [TAXEL_COUNT*4];
    logic signed [15:0] normal_mem [TAXEL_COUNT][3];
    logic signed [15:0] origin_mem [TAXEL_COUNT][3];
    bit coef_seen [TAXEL_COUNT*4];
    bit normal_seen [TAXEL_COUNT];
    bit origin_seen [TAXEL_COUNT];
    longint force_acc [3];
    longint torque_acc [3];
    int unsigned order_reg;
    longint area_reg;

    result_t sums_due [$];
    int errors;
    int cycles;
    row_t rows [$];

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("taxel_polynomial_force_torque_unit test failed");
            $finish;
        end
    end

    function automatic longint clamp48(longint v);
        if (v > S48_HI)
            return S48_HI;
        if (v < S48_LO)
            return S48_LO;
        return v;
    endfunction

    // >>> on longint is arithmetic, i.e. floor division
    function automatic longint scale_by_area(longint p, longint a);
        longint m;
        longint lp;
        longint q;
        m = (p < 0) ? -p : p;
        lp = (m & 64'hFFFFFF) * a;
        q = (m >>> 24) * a + (lp >>> 24);
        if (p >= 0)
            return q;
        if ((lp & 64'hFFFFFF) != 0)
            q = q + 1;
        return -q;
    endfunction

    function automatic bit ready_taxel(int id);
        if (!normal_seen[id] || !origin_seen[id])
            return 0;
        for (int j = 0; j <= order_reg; j++)
            if (!coef_seen[id*4+j])
                return 0;
        return 1;
    endfunction

    task automatic track_contact(sample_t s);
        int id;
        longint x;
        longint acc;
        longint mag;
        longint f [3];
        longint d [3];
        longint t [3];
        result_t r;
        id = s.taxel_id;
        if (s.kind == KIND_COEF)
        begin
            coef_mem[id*4+s.coef_index] = s.coef_value;
            coef_seen[id*4+s.coef_index] = 1;
            return;
        end
        if (s.kind == KIND_NORMAL || s.kind == KIND_ORIGIN)
        begin
            if (s.kind == KIND_NORMAL)
            begin
                normal_mem[id] = '{s.vec_x, s.vec_y, s.vec_z};
                normal_seen[id] = 1;
            end
            else
            begin
                origin_mem[id] = '{s.vec_x, s.vec_y, s.vec_z};
                origin_seen[id] = 1;
            end
            return;
        end
        x = 255 - longint'(s.raw_reading);
        acc = coef_mem[id*4];
        for (int j = 1; j <= order_reg; j++)
            acc = clamp48(acc * x + longint'(coef_mem[id*4+j]));
        mag = scale_by_area(acc, area_reg);
        for (int i = 0; i < 3; i++)
        begin
            f[i] = clamp48((mag * longint'(normal_mem[id][i])) >>> 14);
        end
        d[0] = longint'(origin_mem[id][0]) - longint'(s.vec_x);
        d[1] = longint'(origin_mem[id][1]) - longint'(s.vec_y);
        d[2] = longint'(origin_mem[id][2]) - longint'(s.vec_z);
        t[0] = ((d[1] * f[2]) >>> 12) - ((d[2] * f[1]) >>> 12);
        t[1] = ((d[2] * f[0]) >>> 12) - ((d[0] * f[2]) >>> 12);
        t[2] = ((d[0] * f[1]) >>> 12) - ((d[1] * f[0]) >>> 12);
        for (int i = 0; i < 3; i++)
        begin
            force_acc[i] = clamp48(force_acc[i] + f[i]);
            torque_acc[i] = clamp48(torque_acc[i] + t[i]);
        end
        if (s.last_taxel)
        begin
            r.force_x = force_acc[0][47:0];
            r.force_y = force_acc[1][47:0];
            r.force_z = force_acc[2][47:0];
            r.torque_x = torque_acc[0][47:0];
            r.torque_y = torque_acc[1][47:0];
            r.torque_z = torque_acc[2][47:0];
            sums_due.push_back(r);
            force_acc = '{0, 0, 0};
            torque_acc = '{0, 0, 0};
        end
    endtask

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // result side
    initial
    begin
        int gap;
        result_t want;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            if (gap > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            result_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_ch.valid);
            if (sums_due.size() == 0)
            begin
                report("unexpected result item", 1, 0);
            end
            else
            begin
                want = sums_due.pop_front();
                if (result_ch.data.force_x !== want.force_x)
                    report("force_x", result_ch.data.force_x, want.force_x);
                if (result_ch.data.force_y !== want.force_y)
                    report("force_y", result_ch.data.force_y, want.force_y);
                if (result_ch.data.force_z !== want.force_z)
                    report("force_z", result_ch.data.force_z, want.force_z);
                if (result_ch.data.torque_x !== want.torque_x)
                    report("torque_x", result_ch.data.torque_x, want.torque_x);
                if (result_ch.data.torque_y !== want.torque_y)
                    report("torque_y", result_ch.data.torque_y, want.torque_y);
                if (result_ch.data.torque_z !== want.torque_z)
                    report("torque_z", result_ch.data.torque_z, want.torque_z);
            end
        end
    end

    task automatic send_item(sample_t s);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_ch.data <= s;
        sample_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        track_contact(s);
        @(negedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, int unsigned value);
        sample_ch.valid <= 1'b0;
        while (sums_due.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(value);
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_POLY_ORDER)
            order_reg = value & 3;
        else
            area_reg = value & 24'hFFFFFF;
    endtask

    function automatic sample_t make_item(kind_t k, int id, int slot, int cv,
                                          int vx, int vy, int vz, int raw, int last);
        sample_t s;
        s.kind = k;
        s.taxel_id = 8'(id);
        s.coef_index = 2'(slot);
        s.coef_value = cv;
        s.vec_x = 16'(vx);
        s.vec_y = 16'(vy);
        s.vec_z = 16'(vz);
        s.raw_reading = 8'(raw);
        s.last_taxel = last[0];
        return s;
    endfunction

    // random taxel load: all coefficients, normal and origin
    task automatic load_taxel(int id);
        for (int j = 0; j < 4; j++)
            send_item(make_item(KIND_COEF, id, j,
                ($urandom_range(0, 7) == 0) ? int'($urandom) :
                int'($urandom_range(0, 131071)) - 65536, 0, 0, 0, 0, $urandom_range(0, 1)));
        send_item(make_item(KIND_NORMAL, id, 0, 0, int'($urandom), int'($urandom),
                            int'($urandom), 0, $urandom_range(0, 1)));
        send_item(make_item(KIND_ORIGIN, id, 0, 0, int'($urandom), int'($urandom),
                            int'($urandom), 0, $urandom_range(0, 1)));
    endtask

    initial
    begin
        sample_t s;
        int sent;
        int id;
        result_t z;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sample_ch.valid = 1'b0;
        sample_ch.data = '0;
        errors = 0;
        cycles = 0;
        order_reg = 1;
        area_reg = 0;
        force_acc = '{0, 0, 0};
        torque_acc = '{0, 0, 0};
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        z = '0;
        // area zero after reset: all sums zero
        rows.push_back('{make_item(KIND_COEF, 0, 0, 32'sh7FFFFFFF, 0, 0, 0, 0, 1), 0, z});
        rows.push_back('{make_item(KIND_COEF, 0, 1, 32'sh80000000, 0, 0, 0, 0, 0), 0, z});
        rows.push_back('{make_item(KIND_COEF, 0, 2, 65536, 0, 0, 0, 0, 0), 0, z});
        rows.push_back('{make_item(KIND_COEF, 0, 3, -65536, 0, 0, 0, 0, 0), 0, z});
        rows.push_back('{make_item(KIND_NORMAL, 0, 0, 0, 16384, -32768, 32767, 0, 0), 0, z});
        rows.push_back('{make_item(KIND_ORIGIN, 0, 0, 0, 32767, -32768, 0, 0, 1), 0, z});
        rows.push_back('{make_item(KIND_SAMPLE, 0, 0, 0, -32768, 32767, 0, 0, 1), 1, z});
        rows.push_back('{make_item(KIND_SAMPLE, 0, 0, 0, 0, 0, 0, 255, 1), 1, z});
        foreach (rows[i])
        begin
            send_item(rows[i].item);
            if (rows[i].has_value)
                if (sums_due.size() == 0 || sums_due[$] !== rows[i].value)
                    report("directed row", longint'(i), 0);
        end
        rows.delete();

        // extremes: full area, every order, saturation of the polynomial
        write_reg(REG_AREA_SCALE, 24'hFFFFFF);
        for (int o = 0; o < 4; o++)
        begin
            write_reg(REG_POLY_ORDER, o);
            send_item(make_item(KIND_SAMPLE, 0, 0, 0, 0, 0, 0, 0, 0));
            send_item(make_item(KIND_SAMPLE, 0, 0, 0, 32767, -32768, 1, 128, 0));
            send_item(make_item(KIND_SAMPLE, 0, 0, 0, -32768, 32767, -1, 255, 1));
        end
        sent = 0;
        while (sent < N_RANDOM)
        begin
            case ($urandom_range(0, 5))
                0: write_reg(REG_AREA_SCALE, 24'h000000);
                1: write_reg(REG_AREA_SCALE, 24'hFFFFFF);
                default: write_reg(REG_AREA_SCALE, $urandom_range(0, 24'hFFFFFF));
            endcase
            write_reg(REG_POLY_ORDER, $urandom_range(0, 3));
            for (int k = 0; k < 3; k++)
            begin
                load_taxel($urandom_range(0, 255));
                sent += 6;
            end
            for (int c = 0; c < 8; c++)
            begin
                int n;
                n = $urandom_range(1, 6);
                for (int k = 0; k < n; k++)
                begin
                    do
                        id = $urandom_range(0, 255);
                    while (!ready_taxel(id));
                    s = make_item(KIND_SAMPLE, id, $urandom_range(0, 3), int'($urandom),
                                  int'($urandom), int'($urandom), int'($urandom),
                                  $urandom_range(0, 255), k == n - 1);
                    send_item(s);
                    sent++;
                end
            end
        end
        sample_ch.valid <= 1'b0;
        while (sums_due.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        if (errors == 0)
            $display("taxel_polynomial_force_torque_unit test passed");
        else
            $display("taxel_polynomial_force_torque_unit test failed");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/tpft_pkg.sv
rtl/tpft_in_if.sv
rtl/tpft_out_if.sv
rtl/tpft_ram.sv
rtl/taxel_polynomial_force_torque_unit.sv
rtl/tpft_checker.sv
tb/taxel_polynomial_force_torque_unit_tb.sv
